@@ src/ffha_pkg.sv @@
// shared types and constants for the first-fit heap allocator
`timescale 1ns / 1ps
package ffha_pkg;

    // pass modes broadcast to the cell row
    localparam logic [1:0] MODE_ALLOC = 2'd0;
    localparam logic [1:0] MODE_MARK  = 2'd1;
    localparam logic [1:0] MODE_MERGE = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_OOM     = 2'd1;
    localparam logic [1:0] ST_UNKNOWN = 2'd2;

    // request kinds
    localparam logic KIND_ALLOC   = 1'b0;
    localparam logic KIND_RELEASE = 1'b1;

    // register indexes
    localparam logic REG_HEAP_BASE = 1'b0;
    localparam logic REG_HEAP_SIZE = 1'b1;

    // size rounding and split slack
    localparam logic [32:0] ALIGN_ADD   = 33'd3;
    localparam logic [32:0] ALIGN_MASK  = ~33'd3;
    localparam logic [33:0] SPLIT_SLACK = 34'd4;

    // one segment of the table
    typedef struct packed {
        logic        v;
        logic        u;
        logic [31:0] off;
        logic [31:0] sz;
    } entry_t;

    // packet walking the cell row, one cell per cycle
    typedef struct packed {
        logic        act;
        logic        found;
        logic [1:0]  shamt;
        entry_t      ins;
        logic [31:0] addr;
        logic [31:0] fb;
        logic [31:0] ub;
    } pkt_t;

    // controls broadcast to every cell
    typedef struct packed {
        logic [1:0]  mode;
        logic        init;
        logic        room;
        logic [32:0] need;
        logic [31:0] target;
        logic [31:0] base;
        logic [31:0] init_sz;
    } ctl_t;

endpackage

@@ src/ffha_cell.sv @@
// one table cell: holds a segment and processes the packet passing through
`timescale 1ns / 1ps
module ffha_cell #(
    parameter int IDX = 0,
    parameter int HDR = 12,
    parameter int CW  = 7
) (
    input  logic            clk,
    input  logic            rst_n,
    input  ffha_pkg::ctl_t  ctl,
    input  ffha_pkg::pkt_t  pkt_in,
    input  logic [CW-1:0]   nval_in,
    input  logic [CW-1:0]   nfree_in,
    input  ffha_pkg::entry_t next1,
    input  ffha_pkg::entry_t next2,
    output ffha_pkg::entry_t ent,
    output ffha_pkg::pkt_t  pkt_out,
    output logic [CW-1:0]   nval_out,
    output logic [CW-1:0]   nfree_out
);
    import ffha_pkg::*;

    localparam logic [31:0] HDR_W = 32'(HDR);

    entry_t        ent_reg, ent_next;
    pkt_t          pkt_reg, pkt_next;
    logic [CW-1:0] nval_reg, nval_next;
    logic [CW-1:0] nfree_reg, nfree_next;

    logic [31:0] paddr;
    logic        fit;
    logic        split;
    logic [31:0] boff;
    logic [31:0] bsz;
    logic        m1;
    logic        m2;
    logic [31:0] msz;

    // local datapath for the segment held here
    assign paddr = ctl.base + ent_reg.off + HDR_W;
    assign fit   = ent_reg.v && !ent_reg.u && ({1'b0, ent_reg.sz} >= ctl.need);
    assign split = ctl.room &&
                   ({2'b00, ent_reg.sz} > ({1'b0, ctl.need} + 34'(HDR) + SPLIT_SLACK));
    assign boff  = ent_reg.off + HDR_W + ctl.need[31:0];
    assign bsz   = ent_reg.sz - ctl.need[31:0] - HDR_W;
    assign m1    = ent_reg.v && !ent_reg.u && next1.v && !next1.u;
    assign m2    = m1 && next2.v && !next2.u;
    assign msz   = ent_reg.sz + next1.sz + HDR_W + (m2 ? (next2.sz + HDR_W) : 32'd0);

    // segment update and packet processing
    always_comb
    begin
        ent_next   = ent_reg;
        pkt_next   = pkt_in;
        nval_next  = nval_in;
        nfree_next = nfree_in;
        if (ctl.init)
        begin
            ent_next     = '0;
            if (IDX == 0)
            begin
                ent_next.v  = 1'b1;
                ent_next.sz = ctl.init_sz;
            end
        end
        else if (pkt_in.act)
        begin
            case (ctl.mode)
                MODE_ALLOC:
                begin
                    if (pkt_in.ins.v)
                    begin
                        // ripple the split remainder toward the end
                        ent_next     = pkt_in.ins;
                        pkt_next.ins = ent_reg;
                    end
                    else if (!pkt_in.found && fit)
                    begin
                        ent_next.u     = 1'b1;
                        pkt_next.found = 1'b1;
                        pkt_next.addr  = paddr;
                        if (split)
                        begin
                            ent_next.sz      = ctl.need[31:0];
                            pkt_next.ins.v   = 1'b1;
                            pkt_next.ins.u   = 1'b0;
                            pkt_next.ins.off = boff;
                            pkt_next.ins.sz  = bsz;
                        end
                    end
                end
                MODE_MARK:
                begin
                    if (!pkt_in.found && ent_reg.v && (ctl.target != 32'd0) &&
                        (paddr == ctl.target))
                    begin
                        ent_next.u     = 1'b0;
                        pkt_next.found = 1'b1;
                    end
                end
                MODE_MERGE:
                begin
                    // once merged, later cells close the gap from the right
                    if (pkt_in.shamt == 2'd1)
                    begin
                        ent_next = next1;
                    end
                    else if (pkt_in.shamt == 2'd2)
                    begin
                        ent_next = next2;
                    end
                    else if (m1)
                    begin
                        ent_next.sz    = msz;
                        pkt_next.shamt = m2 ? 2'd2 : 2'd1;
                    end
                end
                default:
                begin
                end
            endcase
            // running totals over the final contents
            if (ent_next.v)
            begin
                nval_next = nval_in + CW'(1);
                if (ent_next.u)
                begin
                    pkt_next.ub = pkt_in.ub + ent_next.sz + HDR_W;
                end
                else
                begin
                    pkt_next.fb = pkt_in.fb + ent_next.sz;
                    nfree_next  = nfree_in + CW'(1);
                end
            end
        end
    end

    // registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ent_reg   <= '0;
            pkt_reg   <= '0;
            nval_reg  <= '0;
            nfree_reg <= '0;
        end
        else
        begin
            ent_reg   <= ent_next;
            pkt_reg   <= pkt_next;
            nval_reg  <= nval_next;
            nfree_reg <= nfree_next;
        end
    end

    assign ent       = ent_reg;
    assign pkt_out   = pkt_reg;
    assign nval_out  = nval_reg;
    assign nfree_out = nfree_reg;

endmodule

@@ src/first_fit_heap_allocator.sv @@
// top level: command port, configuration registers and the row of table cells
`timescale 1ns / 1ps
// First-fit heap allocator with split and coalesce.
// Configuration: cfg_we writes cfg_data into heap_base (index 0) or heap_size
// (index 1); any write rebuilds the table as one free segment, which keeps
// busy high for one cycle. Writes must be made only while the block is idle; the block does not enforce this.
// Commands: an item is taken at a clock edge where start is high and busy is
// low. kind 0 allocates request_size bytes, kind 1 releases free_address.
// Results: done is high for one cycle with address, status and table totals;
// the receiver cannot stall, so results are never held back.
// Timing: a packet walks the row of MAX_SEGMENTS cells, one cell per cycle.
// An allocate takes one walk of the row. A release takes two walks (mark, then
// merge and count). busy stays high until done, so one item is in flight at a
// time and a new item may be taken in the cycle done shows.
// Reset: heap_base 0, heap_size 65536; the table is built in the first
// cycle after reset, during which busy is high.
module first_fit_heap_allocator #(
    parameter int MAX_SEGMENTS = 64,
    parameter int HEADER_BYTES = 12
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        start,
    output logic        busy,
    input  logic        kind,
    input  logic [31:0] request_size,
    input  logic [31:0] free_address,
    output logic        done,
    output logic [31:0] address,
    output logic [1:0]  status,
    output logic [6:0]  segments,
    output logic [6:0]  free_segments,
    output logic [31:0] free_bytes,
    output logic [31:0] used_bytes
);
    import ffha_pkg::*;

    localparam int          CW    = $clog2(MAX_SEGMENTS + 1);
    localparam logic [31:0] HDR_W = 32'(HEADER_BYTES);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_PASS1 = 2'd1;
    localparam logic [1:0] S_PASS2 = 2'd2;

    logic [1:0]    state_reg, state_next;
    logic [31:0]   base_reg, base_next;
    logic [31:0]   size_reg, size_next;
    logic          init_reg, init_next;
    logic          inj_reg, inj_next;
    logic [1:0]    mode_reg, mode_next;
    logic [32:0]   need_reg, need_next;
    logic [31:0]   target_reg, target_next;
    logic [CW-1:0] count_reg, count_next;
    logic          found_reg, found_next;
    logic          done_reg, done_next;
    logic [31:0]   addr_reg, addr_next;
    logic [1:0]    status_reg, status_next;
    logic [6:0]    tb_reg, tb_next;
    logic [6:0]    fbk_reg, fbk_next;
    logic [31:0]   fby_reg, fby_next;
    logic [31:0]   uby_reg, uby_next;

    ctl_t          ctl;
    pkt_t          pk [0:MAX_SEGMENTS];
    logic [CW-1:0] nv [0:MAX_SEGMENTS];
    logic [CW-1:0] nf [0:MAX_SEGMENTS];
    entry_t        en [0:MAX_SEGMENTS+1];
    logic [CW+6:0] tb_wide;
    logic [CW+6:0] fbk_wide;
    logic          accept;
    pkt_t          tail;

    // broadcast controls
    always_comb
    begin
        ctl         = '0;
        ctl.mode    = mode_reg;
        ctl.init    = init_reg;
        ctl.room    = (count_reg < CW'(MAX_SEGMENTS));
        ctl.need    = need_reg;
        ctl.target  = target_reg;
        ctl.base    = base_reg;
        ctl.init_sz = (size_reg >= HDR_W) ? (size_reg - HDR_W) : 32'd0;
    end

    // packet injected at the head of the row
    always_comb
    begin
        pk[0]     = '0;
        pk[0].act = inj_reg;
    end
    assign nv[0] = '0;
    assign nf[0] = '0;
    assign en[MAX_SEGMENTS]     = '0;
    assign en[MAX_SEGMENTS + 1] = '0;

    // the row of cells
    for (genvar g = 0; g < MAX_SEGMENTS; g++)
    begin : g_cell
        ffha_cell #(
            .IDX (g),
            .HDR (HEADER_BYTES),
            .CW  (CW)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .pkt_in    (pk[g]),
            .nval_in   (nv[g]),
            .nfree_in  (nf[g]),
            .next1     (en[g + 1]),
            .next2     (en[g + 2]),
            .ent       (en[g]),
            .pkt_out   (pk[g + 1]),
            .nval_out  (nv[g + 1]),
            .nfree_out (nf[g + 1])
        );
    end

    assign tail     = pk[MAX_SEGMENTS];
    assign tb_wide  = {7'd0, nv[MAX_SEGMENTS]};
    assign fbk_wide = {7'd0, nf[MAX_SEGMENTS]};
    assign busy     = (state_reg != S_IDLE) || init_reg;
    assign accept   = start && !busy;

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        base_next   = base_reg;
        size_next   = size_reg;
        init_next   = 1'b0;
        inj_next    = 1'b0;
        mode_next   = mode_reg;
        need_next   = need_reg;
        target_next = target_reg;
        count_next  = count_reg;
        found_next  = found_reg;
        done_next   = 1'b0;
        addr_next   = addr_reg;
        status_next = status_reg;
        tb_next     = tb_reg;
        fbk_next    = fbk_reg;
        fby_next    = fby_reg;
        uby_next    = uby_reg;
        if (init_reg)
        begin
            count_next = CW'(1);
        end
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    need_next   = ({1'b0, request_size} + ALIGN_ADD) & ALIGN_MASK;
                    target_next = free_address;
                    mode_next   = (kind == KIND_ALLOC) ? MODE_ALLOC : MODE_MARK;
                    inj_next    = 1'b1;
                    state_next  = S_PASS1;
                end
            end
            S_PASS1:
            begin
                if (tail.act)
                begin
                    if (mode_reg == MODE_ALLOC)
                    begin
                        done_next   = 1'b1;
                        addr_next   = tail.found ? tail.addr : 32'd0;
                        status_next = tail.found ? ST_OK : ST_OOM;
                        count_next  = nv[MAX_SEGMENTS];
                        tb_next     = tb_wide[6:0];
                        fbk_next    = fbk_wide[6:0];
                        fby_next    = tail.fb;
                        uby_next    = tail.ub;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        found_next = tail.found;
                        mode_next  = MODE_MERGE;
                        inj_next   = 1'b1;
                        state_next = S_PASS2;
                    end
                end
            end
            S_PASS2:
            begin
                if (tail.act)
                begin
                    done_next   = 1'b1;
                    addr_next   = 32'd0;
                    status_next = ((target_reg == 32'd0) || found_reg) ? ST_OK : ST_UNKNOWN;
                    count_next  = nv[MAX_SEGMENTS];
                    tb_next     = tb_wide[6:0];
                    fbk_next    = fbk_wide[6:0];
                    fby_next    = tail.fb;
                    uby_next    = tail.ub;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        // register writes rebuild the table
        if (cfg_we)
        begin
            case (cfg_index)
                REG_HEAP_BASE: base_next = cfg_data;
                REG_HEAP_SIZE: size_next = cfg_data;
                default:       base_next = base_reg;
            endcase
            init_next = 1'b1;
        end
    end

    // registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            base_reg  <= 32'd0;
            size_reg  <= 32'd65536;
            init_reg  <= 1'b1;
            inj_reg   <= 1'b0;
            mode_reg  <= MODE_ALLOC;
            count_reg <= CW'(1);
            found_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            base_reg  <= base_next;
            size_reg  <= size_next;
            init_reg  <= init_next;
            inj_reg   <= inj_next;
            mode_reg  <= mode_next;
            count_reg <= count_next;
            found_reg <= found_next;
            done_reg  <= done_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        need_reg   <= need_next;
        target_reg <= target_next;
        addr_reg   <= addr_next;
        status_reg <= status_next;
        tb_reg     <= tb_next;
        fbk_reg    <= fbk_next;
        fby_reg    <= fby_next;
        uby_reg    <= uby_next;
    end

    assign done          = done_reg;
    assign address       = addr_reg;
    assign status        = status_reg;
    assign segments      = tb_reg;
    assign free_segments = fbk_reg;
    assign free_bytes    = fby_reg;
    assign used_bytes    = uby_reg;

endmodule

@@ sim/first_fit_heap_allocator_checker.sv @@
// checker for the heap allocator: table predictor and result comparison
`timescale 1ns / 1ps
module first_fit_heap_allocator_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        start,
    input  logic        busy,
    input  logic        kind,
    input  logic [31:0] request_size,
    input  logic [31:0] free_address,
    input  logic        done,
    input  logic [31:0] address,
    input  logic [1:0]  status,
    input  logic [6:0]  segments,
    input  logic [6:0]  free_segments,
    input  logic [31:0] free_bytes,
    input  logic [31:0] used_bytes,
    output int          mismatches,
    output int          results_checked
);
    import ffha_pkg::*;

    localparam int SEGS = 64;
    localparam int HDR  = 12;

    typedef struct packed {
        logic [31:0] address;
        logic [1:0]  status;
        logic [6:0]  segments;
        logic [6:0]  free_segments;
        logic [31:0] free_bytes;
        logic [31:0] used_bytes;
    } alloc_result_t;

    alloc_result_t pending_results[$];

    // shadow heap registers and segment table
    logic [31:0] heap_base_q;
    logic [31:0] heap_size_q;
    logic [63:0] seg_off[SEGS];
    logic [63:0] seg_size[SEGS];
    bit          seg_used[SEGS];
    int          seg_cnt;

    task automatic rebuild_table();
        for (int i = 0; i < SEGS; i++)
        begin
            seg_off[i]  = 0;
            seg_size[i] = 0;
            seg_used[i] = 0;
        end
        seg_size[0] = (heap_size_q >= HDR) ? 64'(heap_size_q) - HDR : 64'd0;
        seg_cnt = 1;
    endtask

    function automatic logic [31:0] payload_addr(int i);
        logic [63:0] a;
        a = 64'(heap_base_q) + seg_off[i] + HDR;
        return a[31:0];
    endfunction

    task automatic drop_entry(int k);
        for (int j = k; j + 1 < seg_cnt; j++)
        begin
            seg_off[j]  = seg_off[j + 1];
            seg_size[j] = seg_size[j + 1];
            seg_used[j] = seg_used[j + 1];
        end
        seg_cnt--;
    endtask

    // first fit with optional split
    task automatic grant_segment(input logic [31:0] req, output logic [31:0] addr,
                                 output logic [1:0] st);
        logic [63:0] need;
        need = (64'(req) + 64'd3) & ~64'd3;
        addr = '0;
        st   = ST_OOM;
        for (int i = 0; i < seg_cnt; i++)
        begin
            if (!seg_used[i] && seg_size[i] >= need)
            begin
                if (seg_size[i] > need + HDR + 4 && seg_cnt < SEGS)
                begin
                    for (int j = seg_cnt; j > i + 1; j--)
                    begin
                        seg_off[j]  = seg_off[j - 1];
                        seg_size[j] = seg_size[j - 1];
                        seg_used[j] = seg_used[j - 1];
                    end
                    seg_off[i + 1]  = seg_off[i] + HDR + need;
                    seg_size[i + 1] = seg_size[i] - need - HDR;
                    seg_used[i + 1] = 0;
                    seg_size[i]     = need;
                    seg_cnt++;
                end
                seg_used[i] = 1;
                addr = payload_addr(i);
                st   = ST_OK;
                return;
            end
        end
    endtask

    // free by payload address, then coalesce free neighbors
    task automatic return_segment(input logic [31:0] where, output logic [1:0] st);
        int i;
        st = ST_OK;
        if (where == 0)
            return;
        for (int k = 0; k < seg_cnt; k++)
        begin
            if (payload_addr(k) == where)
            begin
                seg_used[k] = 0;
                i = 0;
                while (i + 1 < seg_cnt)
                begin
                    if (!seg_used[i] && !seg_used[i + 1])
                    begin
                        seg_size[i] = seg_size[i] + seg_size[i + 1] + HDR;
                        drop_entry(i + 1);
                    end
                    else
                        i++;
                end
                return;
            end
        end
        st = ST_UNKNOWN;
    endtask

    function automatic alloc_result_t table_totals();
        alloc_result_t r;
        logic [63:0] fb;
        logic [63:0] ub;
        int nfree;
        fb = 0;
        ub = 0;
        nfree = 0;
        for (int i = 0; i < seg_cnt; i++)
        begin
            if (seg_used[i])
                ub += seg_size[i] + HDR;
            else
            begin
                nfree++;
                fb += seg_size[i];
            end
        end
        r = '0;
        r.segments      = 7'(seg_cnt);
        r.free_segments = 7'(nfree);
        r.free_bytes    = fb[31:0];
        r.used_bytes    = ub[31:0];
        return r;
    endfunction

    // compare, predict and track registers at each edge
    always @(posedge clk or negedge rst_n)
    begin
        alloc_result_t exp_r;
        alloc_result_t got_r;
        logic [31:0] a;
        logic [1:0]  st;
        if (!rst_n)
        begin
            heap_base_q = 32'd0;
            heap_size_q = 32'd65536;
            rebuild_table();
            pending_results.delete();
            mismatches = 0;
            results_checked = 0;
        end
        else
        begin
            // results leaving the block
            if (done)
            begin
                got_r = '{address, status, segments, free_segments, free_bytes,
                          used_bytes};
                if (pending_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result with no item pending: %p", $realtime, got_r);
                end
                else
                begin
                    exp_r = pending_results.pop_front();
                    results_checked++;
                    if (got_r !== exp_r)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: mismatch expected %p actual %p",
                                     $realtime, exp_r, got_r);
                    end
                end
            end
            // register writes rebuild the table
            if (cfg_we)
            begin
                if (cfg_index == REG_HEAP_BASE)
                    heap_base_q = cfg_data;
                else
                    heap_size_q = cfg_data;
                rebuild_table();
            end
            // accepted item
            if (start && !busy)
            begin
                a = '0;
                if (kind == KIND_ALLOC)
                    grant_segment(request_size, a, st);
                else
                    return_segment(free_address, st);
                exp_r = table_totals();
                exp_r.address = a;
                exp_r.status  = st;
                pending_results.push_back(exp_r);
            end
        end
    end

endmodule

@@ sim/first_fit_heap_allocator_test.sv @@
// testbench top: clock, reset, stimulus and verdict for the heap allocator
`timescale 1ns / 1ps
module first_fit_heap_allocator_test;
    import ffha_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [31:0] cfg_data;
    logic        start;
    logic        busy;
    logic        kind;
    logic [31:0] request_size;
    logic [31:0] free_address;
    logic        done;
    logic [31:0] address;
    logic [1:0]  status;
    logic [6:0]  segments;
    logic [6:0]  free_segments;
    logic [31:0] free_bytes;
    logic [31:0] used_bytes;
    int          mismatches;
    int          results_checked;

    int          items_sent;
    int          results_seen;
    int          max_gap;
    int          alloc_count;
    int          release_count;
    logic [31:0] live_addrs[$];

    first_fit_heap_allocator dut (.*);

    first_fit_heap_allocator_checker checker_i (.*);

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // collect granted addresses for later releases
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            results_seen++;
            if (status == ST_OK && address != 0 && live_addrs.size() < 200)
                live_addrs.push_back(address);
        end
    end

    // one command item, with a random lead-in gap
    task automatic send_item(logic k, logic [31:0] rs, logic [31:0] fa);
        int gap;
        gap = $urandom_range(0, max_gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start        <= 1'b1;
        kind         <= k;
        request_size <= rs;
        free_address <= fa;
        items_sent++;
        if (k == KIND_ALLOC)
            alloc_count++;
        else
            release_count++;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (results_seen != items_sent)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_heap(logic [31:0] base, logic [31:0] size);
        cfg_we    <= 1'b1;
        cfg_index <= REG_HEAP_BASE;
        cfg_data  <= base;
        @(posedge clk);
        cfg_index <= REG_HEAP_SIZE;
        cfg_data  <= size;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        live_addrs.delete();
    endtask

    // mostly real allocations and releases, some noise
    task automatic random_items(int n);
        logic [31:0] fa;
        int pick;
        max_gap = ($urandom_range(0, 2) == 0) ? 0 : 16;
        for (int i = 0; i < n; i++)
        begin
            if (i % 40 == 20)
                max_gap = ($urandom_range(0, 2) == 0) ? 0 : 16;
            if (live_addrs.size() == 0 || $urandom_range(0, 99) < 55)
            begin
                case ($urandom_range(0, 19))
                    0:       send_item(KIND_ALLOC, $urandom(), $urandom());
                    1:       send_item(KIND_ALLOC, 32'hFFFF_FFFF - $urandom_range(0, 3),
                                       $urandom());
                    2:       send_item(KIND_ALLOC, $urandom_range(0, 70000), $urandom());
                    default: send_item(KIND_ALLOC, $urandom_range(0, 300), $urandom());
                endcase
            end
            else
            begin
                pick = $urandom_range(0, live_addrs.size() - 1);
                case ($urandom_range(0, 9))
                    0:       fa = 32'd0;
                    1:       fa = $urandom();
                    2:       fa = live_addrs[pick] + 4;
                    default: fa = live_addrs[pick];
                endcase
                if (fa == live_addrs[pick] && $urandom_range(0, 4) != 0)
                    live_addrs.delete(pick);
                send_item(KIND_RELEASE, $urandom(), fa);
            end
        end
        wait_idle();
    endtask

    // main sequence
    initial
    begin
        rst_n        <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_index    <= REG_HEAP_BASE;
        cfg_data     <= '0;
        start        <= 1'b0;
        kind         <= KIND_ALLOC;
        request_size <= '0;
        free_address <= '0;
        items_sent = 0;
        results_seen = 0;
        alloc_count = 0;
        release_count = 0;
        max_gap = 3;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (3) @(posedge clk);

        // directed: rounding, huge sizes, bad and double releases
        send_item(KIND_ALLOC, 32'd0, 32'd0);
        send_item(KIND_ALLOC, 32'd1, 32'd0);
        send_item(KIND_ALLOC, 32'd3, 32'hFFFF_FFFF);
        send_item(KIND_ALLOC, 32'd4, 32'd0);
        send_item(KIND_ALLOC, 32'd5, 32'd0);
        send_item(KIND_ALLOC, 32'hFFFF_FFFF, 32'd0);
        send_item(KIND_ALLOC, 32'hFFFF_FFFC, 32'd0);
        send_item(KIND_RELEASE, 32'hFFFF_FFFF, 32'd0);
        send_item(KIND_RELEASE, 32'd0, 32'h1234_5677);
        wait_idle();
        send_item(KIND_RELEASE, 32'd0, live_addrs[1]);
        send_item(KIND_RELEASE, 32'd0, live_addrs[1]);
        send_item(KIND_RELEASE, 32'd0, live_addrs[0]);
        send_item(KIND_ALLOC, 32'd65000, 32'd0);
        send_item(KIND_ALLOC, 32'd500, 32'd0);
        wait_idle();
        live_addrs.delete();
        random_items(150);

        // several heap settings, the extremes among them
        write_heap(32'h0000_1000, 32'd4096);
        random_items(140);
        write_heap(32'hFFFF_FF00, 32'd2048);
        random_items(140);
        write_heap(32'd0, 32'd16);
        send_item(KIND_ALLOC, 32'd4, 32'd0);
        send_item(KIND_ALLOC, 32'd0, 32'd0);
        send_item(KIND_RELEASE, 32'd0, 32'd12);
        send_item(KIND_ALLOC, 32'd5, 32'd0);
        random_items(40);
        write_heap(32'h8000_0000, 32'hFFFF_FFFF);
        random_items(140);
        write_heap($urandom(), $urandom_range(1000, 20000));
        random_items(140);

        repeat (20) @(posedge clk);
        $display("covered %0d items (%0d allocate, %0d release), %0d results checked",
                 items_sent, alloc_count, release_count, results_checked);
        $display("six heap settings incl. minimum, maximum and wrapping base");
        if (mismatches == 0 && checker_i.pending_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // run limit
    initial
    begin
        #10ms;
        $display("timeout");
        $display("status: fail");
        $finish;
    end

endmodule
